/* sv/acl_pkg.sv */
package acl_pkg;

  localparam int CODE_W     = 4;
  localparam int LEVEL_W    = 12;
  localparam int PERIOD_W   = 16;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNLOCK_CODE      = 3'd0,
    REG_OVER_TEMP_LEVEL  = 3'd1,
    REG_BLINK_GAS_TICKS  = 3'd2,
    REG_BLINK_TEMP_TICKS = 3'd3,
    REG_BLINK_BOTH_TICKS = 3'd4,
    REG_LOCKOUT_LIMIT    = 3'd5
  } reg_idx_t;

  localparam logic [CODE_W-1:0]   RST_UNLOCK_CODE      = 4'd3;
  localparam int                  RST_OVER_TEMP_LEVEL  = 620;
  localparam logic [PERIOD_W-1:0] RST_BLINK_GAS_TICKS  = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_BLINK_TEMP_TICKS = 16'd50;
  localparam logic [PERIOD_W-1:0] RST_BLINK_BOTH_TICKS = 16'd10;
  localparam logic [LIMIT_W-1:0]  RST_LOCKOUT_LIMIT    = 4'd5;

  localparam logic [CODE_W-1:0]   KEYS_ALL  = 4'hF;
  localparam logic [PERIOD_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CODE_W-1:0]   unlock_code;
    logic [PERIOD_W-1:0] blink_gas_ticks;
    logic [PERIOD_W-1:0] blink_temp_ticks;
    logic [PERIOD_W-1:0] blink_both_ticks;
    logic [LIMIT_W-1:0]  lockout_limit;
  } ctrl_cfg_t;

  typedef struct packed {
    logic              gas_n;
    logic              test;
    logic [CODE_W-1:0] keys;
    logic              enter;
  } tick_in_t;

  typedef struct packed {
    logic alarm_active;
    logic alarm_led;
    logic siren_on;
    logic over_temp;
    logic gas_cause;
    logic temp_cause;
    logic wrong_code_led;
    logic blocked_led;
  } result_t;

endpackage

/* sv/acl_cell.sv */
module acl_cell #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift_en,
  input  logic [SAMPLE_BITS-1:0] d,
  output logic [SAMPLE_BITS-1:0] q
);

  logic [SAMPLE_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

/* sv/acl_window.sv */
module acl_window #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = 19,
  parameter int THR_W       = 19
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THR_W-1:0]       thr,
  output logic                   over
);

  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [SAMPLE_BITS-1:0] tap [WINDOW];
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;

  // Each accepted item pushes the new sample into the first cell; the sample
  // falling out of the last cell is the one leaving the window.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      acl_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .d        (sample),
        .q        (tap[i])
      );
    end else begin : g_body
      acl_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .d        (tap[i-1]),
        .q        (tap[i])
      );
    end
  end

  assign sum_nxt = sum_r - SUM_W'(tap[WINDOW-1]) + SUM_W'(sample);
  assign over    = CMP_W'(sum_nxt) > CMP_W'(thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (accept) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

/* sv/acl_ctrl.sv */
module acl_ctrl
  import acl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  tick_in_t   tick,
  input  logic       over,
  input  ctrl_cfg_t  cfg,
  output result_t    res_nxt
);

  logic                alarm_r, alarm_nxt;
  logic                gas_r, gas_nxt;
  logic                temp_r, temp_nxt;
  logic [PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic                led_r, led_nxt;
  logic                wrong_r, wrong_nxt;
  logic [LIMIT_W-1:0]  wcnt_r, wcnt_nxt;
  logic                blocked_r, blocked_nxt;

  logic                gas;
  logic                alarm_mid;
  logic [PERIOD_W-1:0] cnt_inc;
  logic [PERIOD_W-1:0] period;

  always_comb begin
    gas         = !tick.gas_n;
    alarm_mid   = alarm_r | gas | over | tick.test;
    gas_nxt     = gas_r | gas | tick.test;
    temp_nxt    = temp_r | over | tick.test;
    cnt_nxt     = cnt_r;
    led_nxt     = led_r;
    wrong_nxt   = wrong_r;
    wcnt_nxt    = wcnt_r;
    blocked_nxt = blocked_r;
    cnt_inc     = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;

    if (gas_nxt && temp_nxt) begin
      period = cfg.blink_both_ticks;
    end else if (gas_nxt) begin
      period = cfg.blink_gas_ticks;
    end else begin
      period = cfg.blink_temp_ticks;
    end

    if (alarm_mid) begin
      // The counter keeps running while the alarm is on and only restarts
      // when the LED toggles; it is left alone while the alarm is off.
      cnt_nxt = cnt_inc;
      if ((gas_nxt || temp_nxt) && cnt_inc >= period) begin
        cnt_nxt = '0;
        led_nxt = !led_r;
      end
    end else begin
      led_nxt  = 1'b0;
      gas_nxt  = 1'b0;
      temp_nxt = 1'b0;
    end

    alarm_nxt = alarm_mid;
    if (wcnt_r < cfg.lockout_limit) begin
      if (tick.keys == KEYS_ALL && !tick.enter) begin
        wrong_nxt = 1'b0;
      end
      if (tick.enter && !wrong_r && alarm_mid) begin
        if (tick.keys == cfg.unlock_code) begin
          alarm_nxt = 1'b0;
          wcnt_nxt  = '0;
        end else begin
          wrong_nxt = 1'b1;
          wcnt_nxt  = wcnt_r + 1'b1;
        end
      end
    end else begin
      blocked_nxt = 1'b1;
    end

    res_nxt.alarm_active   = alarm_nxt;
    res_nxt.alarm_led      = led_nxt;
    res_nxt.siren_on       = alarm_mid;
    res_nxt.over_temp      = over;
    res_nxt.gas_cause      = gas_nxt;
    res_nxt.temp_cause     = temp_nxt;
    res_nxt.wrong_code_led = wrong_nxt;
    res_nxt.blocked_led    = blocked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r   <= 1'b0;
      gas_r     <= 1'b0;
      temp_r    <= 1'b0;
      cnt_r     <= '0;
      led_r     <= 1'b0;
      wrong_r   <= 1'b0;
      wcnt_r    <= '0;
      blocked_r <= 1'b0;
    end else if (accept) begin
      alarm_r   <= alarm_nxt;
      gas_r     <= gas_nxt;
      temp_r    <= temp_nxt;
      cnt_r     <= cnt_nxt;
      led_r     <= led_nxt;
      wrong_r   <= wrong_nxt;
      wcnt_r    <= wcnt_nxt;
      blocked_r <= blocked_nxt;
    end
  end

endmodule

/* sv/alarm_controller_with_code_lockout_unit.sv */
// Alarm controller with keypad code lockout.
// Input channel (in_valid/in_ready): one item per sensor tick, carrying the raw
// temperature sample, the active-low gas level and the button levels. Output
// channel (out_valid/out_ready): exactly one result item per input item, in
// order, with the alarm, LED, siren, cause and code status flags.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; writes take effect for the next item. Unknown indexes are dropped.
// The window of the last WINDOW samples is a chain of cells that shifts on
// every accepted item, and the running sum, threshold compare and alarm logic
// settle in the same cycle as acceptance, and the result is then written into
// the result queue. A new item can be accepted every cycle while the queue has room.
// A two-entry result queue sits on the output, so one item is still accepted
// while a result waits; in_ready drops only when both entries are full.
// Synchronous reset clears the sample window, the running sum, all alarm and
// code state and the result queue, and loads the register defaults.
// The over-temperature threshold level * WINDOW is computed when the level is
// written, so the per-item compare needs no multiplier.
module alarm_controller_with_code_lockout_unit
  import acl_pkg::*;
#(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_temp_sample,
  input  logic                   in_gas_level_n,
  input  logic                   in_test_button,
  input  logic                   in_key_a,
  input  logic                   in_key_b,
  input  logic                   in_key_c,
  input  logic                   in_key_d,
  input  logic                   in_enter_button,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_alarm_active,
  output logic                   out_alarm_led,
  output logic                   out_siren_on,
  output logic                   out_over_temp,
  output logic                   out_gas_cause,
  output logic                   out_temp_cause,
  output logic                   out_wrong_code_led,
  output logic                   out_blocked_led,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_BITS = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_BITS;
  localparam int THR_W    = LEVEL_W + CNT_BITS;

  ctrl_cfg_t        cfg_r;
  logic [THR_W-1:0] thr_r;
  logic             in_acc;
  logic             out_acc;
  logic             cfg_acc;
  logic             over;
  tick_in_t         tick;
  result_t          res_nxt;

  result_t          q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  result_t          head;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_ready  = (fill_r != 2'd2);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = (fill_r != 2'd0);
  assign out_acc   = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unlock_code      <= RST_UNLOCK_CODE;
      cfg_r.blink_gas_ticks  <= RST_BLINK_GAS_TICKS;
      cfg_r.blink_temp_ticks <= RST_BLINK_TEMP_TICKS;
      cfg_r.blink_both_ticks <= RST_BLINK_BOTH_TICKS;
      cfg_r.lockout_limit    <= RST_LOCKOUT_LIMIT;
      thr_r                  <= THR_W'(RST_OVER_TEMP_LEVEL * WINDOW);
    end else if (cfg_acc) begin
      case (reg_idx_t'(cfg_index))
        REG_UNLOCK_CODE:      cfg_r.unlock_code      <= cfg_data[CODE_W-1:0];
        REG_OVER_TEMP_LEVEL:  thr_r <= THR_W'(cfg_data[LEVEL_W-1:0]) * THR_W'(WINDOW);
        REG_BLINK_GAS_TICKS:  cfg_r.blink_gas_ticks  <= cfg_data[PERIOD_W-1:0];
        REG_BLINK_TEMP_TICKS: cfg_r.blink_temp_ticks <= cfg_data[PERIOD_W-1:0];
        REG_BLINK_BOTH_TICKS: cfg_r.blink_both_ticks <= cfg_data[PERIOD_W-1:0];
        REG_LOCKOUT_LIMIT:    cfg_r.lockout_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick.gas_n = in_gas_level_n;
  assign tick.test  = in_test_button;
  assign tick.keys  = {in_key_d, in_key_c, in_key_b, in_key_a};
  assign tick.enter = in_enter_button;

  acl_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .THR_W       (THR_W)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .sample (in_temp_sample),
    .thr    (thr_r),
    .over   (over)
  );

  acl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .tick    (tick),
    .over    (over),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r[wr_ptr_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (out_acc) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (in_acc && !out_acc) begin
        fill_r <= fill_r + 2'd1;
      end else if (out_acc && !in_acc) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  assign head               = q_r[rd_ptr_r];
  assign out_alarm_active   = head.alarm_active;
  assign out_alarm_led      = head.alarm_led;
  assign out_siren_on       = head.siren_on;
  assign out_over_temp      = head.over_temp;
  assign out_gas_cause      = head.gas_cause;
  assign out_temp_cause     = head.temp_cause;
  assign out_wrong_code_led = head.wrong_code_led;
  assign out_blocked_led    = head.blocked_led;

endmodule

/* dv/acl_check_pkg.sv */
package acl_check_pkg;

  import acl_pkg::*;

  localparam int WINDOW_LEN = 100;
  localparam int TEMP_W     = 12;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_sample;
    logic              gas_n;
    logic              test;
    logic [CODE_W-1:0] keys;
    logic              enter;
  } sensor_tick_t;

  class alarm_scoreboard;

    logic [CODE_W-1:0]   unlock_code;
    logic [LEVEL_W-1:0]  over_level;
    logic [PERIOD_W-1:0] gas_period;
    logic [PERIOD_W-1:0] temp_period;
    logic [PERIOD_W-1:0] both_period;
    logic [LIMIT_W-1:0]  wrong_limit;

    logic [TEMP_W-1:0]   samples [WINDOW_LEN];
    int unsigned         sample_pos;
    int unsigned         sample_sum;
    bit                  alarm_on;
    bit                  gas_latch;
    bit                  temp_latch;
    bit                  led_on;
    bit                  wrong_lit;
    bit                  blocked;
    logic [PERIOD_W-1:0] blink_ticks;
    logic [LIMIT_W-1:0]  wrong_tries;

    result_t             expected_flags_q[$];
    int                  errors;

    function new();
      unlock_code = RST_UNLOCK_CODE;
      over_level  = LEVEL_W'(RST_OVER_TEMP_LEVEL);
      gas_period  = RST_BLINK_GAS_TICKS;
      temp_period = RST_BLINK_TEMP_TICKS;
      both_period = RST_BLINK_BOTH_TICKS;
      wrong_limit = RST_LOCKOUT_LIMIT;
      foreach (samples[i]) samples[i] = '0;
      sample_pos  = 0;
      sample_sum  = 0;
      alarm_on    = 1'b0;
      gas_latch   = 1'b0;
      temp_latch  = 1'b0;
      led_on      = 1'b0;
      wrong_lit   = 1'b0;
      blocked     = 1'b0;
      blink_ticks = '0;
      wrong_tries = '0;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_UNLOCK_CODE:      unlock_code = data[CODE_W-1:0];
        REG_OVER_TEMP_LEVEL:  over_level  = data[LEVEL_W-1:0];
        REG_BLINK_GAS_TICKS:  gas_period  = data[PERIOD_W-1:0];
        REG_BLINK_TEMP_TICKS: temp_period = data[PERIOD_W-1:0];
        REG_BLINK_BOTH_TICKS: both_period = data[PERIOD_W-1:0];
        REG_LOCKOUT_LIMIT:    wrong_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the flags of one tick: window, cause latching, LED and siren,
    // then code entry, in that order.
    function void note_tick(sensor_tick_t t);
      result_t             r;
      bit                  over;
      bit                  siren;
      bit                  have;
      logic [PERIOD_W-1:0] period;
      sample_sum = sample_sum - samples[sample_pos] + t.temp_sample;
      samples[sample_pos] = t.temp_sample;
      sample_pos = (sample_pos + 1) % WINDOW_LEN;
      over = sample_sum > over_level * WINDOW_LEN;

      if (!t.gas_n) begin
        gas_latch = 1'b1;
        alarm_on  = 1'b1;
      end
      if (over) begin
        temp_latch = 1'b1;
        alarm_on   = 1'b1;
      end
      if (t.test) begin
        gas_latch  = 1'b1;
        temp_latch = 1'b1;
        alarm_on   = 1'b1;
      end

      siren = alarm_on;
      if (alarm_on) begin
        have   = 1'b1;
        period = '0;
        if (blink_ticks != COUNT_MAX) blink_ticks++;
        if (gas_latch && temp_latch) period = both_period;
        else if (gas_latch) period = gas_period;
        else if (temp_latch) period = temp_period;
        else have = 1'b0;
        if (have && blink_ticks >= period) begin
          blink_ticks = '0;
          led_on      = !led_on;
        end
      end else begin
        led_on     = 1'b0;
        gas_latch  = 1'b0;
        temp_latch = 1'b0;
      end

      if (wrong_tries < wrong_limit) begin
        if (t.keys == KEYS_ALL && !t.enter) wrong_lit = 1'b0;
        if (t.enter && !wrong_lit && alarm_on) begin
          if (t.keys == unlock_code) begin
            alarm_on    = 1'b0;
            wrong_tries = '0;
          end else begin
            wrong_lit   = 1'b1;
            wrong_tries = wrong_tries + 1'b1;
          end
        end
      end else begin
        blocked = 1'b1;
      end

      r.alarm_active   = alarm_on;
      r.alarm_led      = led_on;
      r.siren_on       = siren;
      r.over_temp      = over;
      r.gas_cause      = gas_latch;
      r.temp_cause     = temp_latch;
      r.wrong_code_led = wrong_lit;
      r.blocked_led    = blocked;
      expected_flags_q.push_back(r);
    endfunction

    function int pending();
      return expected_flags_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_flag(string name, logic got, logic want);
      if (got !== want) report($sformatf("%s got %b, expected %b", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_flags_q.size() == 0) begin
        report("result item arrived with nothing expected");
      end else begin
        want = expected_flags_q.pop_front();
        compare_flag("alarm_active", got.alarm_active, want.alarm_active);
        compare_flag("alarm_led", got.alarm_led, want.alarm_led);
        compare_flag("siren_on", got.siren_on, want.siren_on);
        compare_flag("over_temp", got.over_temp, want.over_temp);
        compare_flag("gas_cause", got.gas_cause, want.gas_cause);
        compare_flag("temp_cause", got.temp_cause, want.temp_cause);
        compare_flag("wrong_code_led", got.wrong_code_led, want.wrong_code_led);
        compare_flag("blocked_led", got.blocked_led, want.blocked_led);
      end
    endtask

  endclass

endpackage

/* dv/alarm_controller_with_code_lockout_unit_test.sv */
module alarm_controller_with_code_lockout_unit_test;

  import acl_pkg::*;
  import acl_check_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 9;
  localparam int TICKS_PER_PHASE = 100;
  localparam int PH_PRESSURE     = 3;
  localparam int PH_CALM         = 4;
  localparam int HOLD_CYCLES     = 80;
  localparam int IDLE_PCT        = 21;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TEMP_MAX        = 4095;
  localparam int TEMP_SPAN       = 300;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [TEMP_W-1:0]     in_temp_sample;
  logic                  in_gas_level_n;
  logic                  in_test_button;
  logic                  in_key_a;
  logic                  in_key_b;
  logic                  in_key_c;
  logic                  in_key_d;
  logic                  in_enter_button;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_alarm_active;
  logic                  out_alarm_led;
  logic                  out_siren_on;
  logic                  out_over_temp;
  logic                  out_gas_cause;
  logic                  out_temp_cause;
  logic                  out_wrong_code_led;
  logic                  out_blocked_led;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  alarm_scoreboard sb;
  bit              calm;
  int              hold_left;
  int              temp_lo;
  int              temp_hi;
  int unsigned     cycles;

  alarm_controller_with_code_lockout_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("alarm_controller_with_code_lockout_unit_test: done, errors");
        $finish;
      end
    end
  end

  // The receiver stalls at random, and on request holds off for a long stretch
  // so that the result queue fills and the block stops taking items.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watch_results
    result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.alarm_active   = out_alarm_active;
        got.alarm_led      = out_alarm_led;
        got.siren_on       = out_siren_on;
        got.over_temp      = out_over_temp;
        got.gas_cause      = out_gas_cause;
        got.temp_cause     = out_temp_cause;
        got.wrong_code_led = out_wrong_code_led;
        got.blocked_led    = out_blocked_led;
        sb.check_result(got);
      end
    end
  end

  function automatic int idle_gap();
    int n;
    n = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) n++;
    end
    return n;
  endfunction

  function automatic sensor_tick_t tick_of(int sample, bit gas_n, bit test,
                                           logic [CODE_W-1:0] keys, bit enter);
    sensor_tick_t t;
    t.temp_sample = TEMP_W'(sample);
    t.gas_n       = gas_n;
    t.test        = test;
    t.keys        = keys;
    t.enter       = enter;
    return t;
  endfunction

  // Mostly well-formed code entry against the current unlock code, with
  // occasional gas, test presses and stray samples mixed in.
  function automatic sensor_tick_t random_tick();
    sensor_tick_t t;
    int           pick;
    if ($urandom_range(99) < 3) t.temp_sample = TEMP_W'($urandom_range(TEMP_MAX, 0));
    else t.temp_sample = TEMP_W'($urandom_range(temp_hi, temp_lo));
    t.gas_n = ($urandom_range(99) >= 5);
    t.test  = ($urandom_range(99) < 3);
    t.keys  = CODE_W'($urandom);
    t.enter = 1'b0;
    pick = $urandom_range(99);
    if (pick < 30) begin
      t.keys  = sb.unlock_code;
      t.enter = 1'b1;
    end else if (pick < 45) begin
      t.enter = 1'b1;
    end else if (pick < 60) begin
      t.keys = KEYS_ALL;
    end else if (pick < 70) begin
      t.enter = 1'($urandom);
    end else begin
      t.keys = '0;
    end
    return t;
  endfunction

  task automatic send_tick(sensor_tick_t t);
    int gap;
    in_valid        <= 1'b1;
    in_temp_sample  <= t.temp_sample;
    in_gas_level_n  <= t.gas_n;
    in_test_button  <= t.test;
    in_key_a        <= t.keys[0];
    in_key_b        <= t.keys[1];
    in_key_c        <= t.keys[2];
    in_key_d        <= t.keys[3];
    in_enter_button <= t.enter;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, data);
  endtask

  // Register settings per phase; the upper data bits beyond each register's
  // width carry noise that the block must drop.
  task automatic program_phase(int p);
    logic [CODE_W-1:0]   code;
    logic [LEVEL_W-1:0]  level;
    logic [PERIOD_W-1:0] pg;
    logic [PERIOD_W-1:0] pt;
    logic [PERIOD_W-1:0] pb;
    logic [LIMIT_W-1:0]  lim;
    code  = CODE_W'($urandom);
    level = LEVEL_W'($urandom_range(TEMP_MAX, 0));
    pg    = PERIOD_W'($urandom_range(30, 0));
    pt    = PERIOD_W'($urandom_range(30, 0));
    pb    = PERIOD_W'($urandom_range(30, 0));
    lim   = '1;
    case (p)
      0: begin
        code  = '0;
        level = LEVEL_W'(RST_OVER_TEMP_LEVEL);
        pg    = 16'd1;
        pt    = 16'd1;
        pb    = 16'd1;
      end
      1: begin
        code  = '1;
        level = '0;
        pg    = '0;
        pt    = '0;
        pb    = '0;
      end
      2: begin
        level = '1;
        pg    = '1;
        pt    = '1;
        pb    = '1;
        lim   = RST_LOCKOUT_LIMIT;
      end
      5: lim = RST_LOCKOUT_LIMIT;
      6: lim = 4'd1;
      7: lim = '0;
      8: begin
        code  = '1;
        level = LEVEL_W'(RST_OVER_TEMP_LEVEL);
      end
      default: ;
    endcase
    cfg_write(IDX_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_write(REG_UNLOCK_CODE, {12'($urandom), code});
    cfg_write(REG_OVER_TEMP_LEVEL, {4'($urandom), level});
    cfg_write(REG_BLINK_GAS_TICKS, pg);
    cfg_write(REG_BLINK_TEMP_TICKS, pt);
    cfg_write(REG_BLINK_BOTH_TICKS, pb);
    cfg_write(REG_LOCKOUT_LIMIT, {12'($urandom), lim});
    cfg_write(IDX_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    // Samples straddle the level so that the window mean crosses it.
    temp_lo = (level > TEMP_SPAN) ? level - TEMP_SPAN : 0;
    temp_hi = (level + TEMP_SPAN > TEMP_MAX) ? TEMP_MAX : level + TEMP_SPAN;
  endtask

  initial begin
    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_temp_sample  = '0;
    in_gas_level_n  = 1'b1;
    in_test_button  = 1'b0;
    in_key_a        = 1'b0;
    in_key_b        = 1'b0;
    in_key_c        = 1'b0;
    in_key_d        = 1'b0;
    in_enter_button = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    calm            = 1'b0;
    hold_left       = 0;
    temp_lo         = 0;
    temp_hi         = TEMP_MAX;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(tick_of(0, 1'b1, 1'b0, '0, 1'b0));
    send_tick(tick_of(TEMP_MAX, 1'b1, 1'b0, '0, 1'b0));
    // Enter while the alarm is off does nothing.
    send_tick(tick_of(0, 1'b1, 1'b0, KEYS_ALL, 1'b1));
    send_tick(tick_of(0, 1'b0, 1'b0, '0, 1'b0));
    send_tick(tick_of(0, 1'b1, 1'b0, '0, 1'b0));
    send_tick(tick_of(2730, 1'b1, 1'b0, 4'h5, 1'b1));
    // The right code is ignored while the error LED is still lit.
    send_tick(tick_of(1365, 1'b1, 1'b0, RST_UNLOCK_CODE, 1'b1));
    send_tick(tick_of(0, 1'b1, 1'b0, KEYS_ALL, 1'b0));
    send_tick(tick_of(0, 1'b1, 1'b0, RST_UNLOCK_CODE, 1'b1));
    send_tick(tick_of(0, 1'b1, 1'b0, '0, 1'b0));
    send_tick(tick_of(0, 1'b1, 1'b1, 4'hA, 1'b0));
    send_tick(tick_of(0, 1'b1, 1'b0, '0, 1'b0));
    send_tick(tick_of(0, 1'b1, 1'b0, '0, 1'b0));
    send_tick(tick_of(TEMP_MAX, 1'b1, 1'b0, KEYS_ALL, 1'b1));
    send_tick(tick_of(0, 1'b1, 1'b0, KEYS_ALL, 1'b0));
    send_tick(tick_of(0, 1'b1, 1'b0, RST_UNLOCK_CODE, 1'b1));
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      program_phase(p);
      calm = (p == PH_CALM);
      if (p == PH_PRESSURE) hold_left = HOLD_CYCLES;
      repeat (TICKS_PER_PHASE) send_tick(random_tick());
      drain_results();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("alarm_controller_with_code_lockout_unit_test: done, clean");
    end else begin
      $display("alarm_controller_with_code_lockout_unit_test: done, errors");
    end
    $finish;
  end

endmodule
